// ----- rtl/sfsd_pkg.sv -----
// Shared constants, register codes and types for the spectral flux shot detector.
// No dependencies; every other file imports this package.
package sfsd_pkg;

  localparam int unsigned SFSD_BINS = 32;   // default frame length in bins
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned FLUX_W    = 21;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned FLOOR_W   = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FLUX_W-1:0] FLUX_THR_RST   = 21'd900;
  localparam logic [CNT_W-1:0]  COUNT_THR_RST  = 5'd29;
  localparam logic [CFG_W-1:0]  FLOOR_LOW_RST  = 64'd9833442074477229952;
  localparam logic [CFG_W-1:0]  FLOOR_HIGH_RST = 64'd8608461730003449702;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLUX_THR   = 2'd0,
    REG_COUNT_THR  = 2'd1,
    REG_FLOOR_LOW  = 2'd2,
    REG_FLOOR_HIGH = 2'd3
  } cfg_reg_e;

  // per-beat control from the bin sequencer to the accumulator
  typedef struct packed {
    logic accept;   // input beat taken this cycle
    logic first;    // bin 0: store only
    logic last;     // last bin of the frame: emit result
  } step_t;

endpackage

// ----- rtl/sfsd_if.sv -----
// Valid/ready channel interfaces: spectrum bins in, frame results out.
// Depends on sfsd_pkg for field widths.
interface sfsd_mag_if import sfsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MAG_W-1:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

interface sfsd_res_if import sfsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              detected;
  logic [FLUX_W-1:0] flux_sum;
  logic [CNT_W-1:0]  active_count;

  modport source (output valid, output detected, output flux_sum, output active_count,
                  input ready);
  modport sink   (input valid, input detected, input flux_sum, input active_count,
                  output ready);
endinterface

// ----- rtl/sfsd_cell.sv -----
// One cell of the previous-frame delay line: holds one bin magnitude.
// Depends on sfsd_pkg.
module sfsd_cell import sfsd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    shift_i,
  input  logic signed [MAG_W-1:0] mag_i,
  output logic signed [MAG_W-1:0] mag_o
);

  logic signed [MAG_W-1:0] mag_q;

  // previous frame resets to zero, so this cell clears too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
    end else if (shift_i) begin
      mag_q <= mag_i;
    end
  end

  assign mag_o = mag_q;

endmodule

// ----- rtl/sfsd_accum.sv -----
// Per-bin flux/active accumulation and the registered frame result.
// Depends on sfsd_pkg and sfsd_if.
module sfsd_accum import sfsd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  step_t                   step_i,
  input  logic signed [MAG_W-1:0] mag_i,
  input  logic signed [MAG_W-1:0] prev_i,
  input  logic [FLOOR_W-1:0]      floor_i,
  input  logic [FLUX_W-1:0]       flux_thr_i,
  input  logic [CNT_W-1:0]        count_thr_i,
  sfsd_res_if.source              res_o
);

  logic signed [MAG_W:0] diff;
  logic [MAG_W:0]        diff_neg;
  logic [MAG_W-1:0]      abs_diff;
  logic                  above;
  logic [FLUX_W-1:0]     flux_q, flux_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  valid_q;
  logic                  det_q;
  logic [FLUX_W-1:0]     flux_out_q;
  logic [CNT_W-1:0]      cnt_out_q;

  assign diff     = {mag_i[MAG_W-1], mag_i} - {prev_i[MAG_W-1], prev_i};
  assign diff_neg = -diff;
  assign abs_diff = diff[MAG_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
  // floor test reads the magnitude bits as unsigned
  assign above    = $unsigned(mag_i) > {{(MAG_W-FLOOR_W){1'b0}}, floor_i};

  always_comb begin
    flux_d = flux_q;
    cnt_d  = cnt_q;
    if (!step_i.first) begin
      flux_d = flux_q + {{(FLUX_W-MAG_W){1'b0}}, abs_diff};
      cnt_d  = cnt_q + {{(CNT_W-1){1'b0}}, above};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (step_i.accept) begin
        if (step_i.last) begin
          flux_q <= '0;
          cnt_q  <= '0;
        end else begin
          flux_q <= flux_d;
          cnt_q  <= cnt_d;
        end
      end
      if (step_i.accept && step_i.last) begin
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.accept && step_i.last) begin
      det_q      <= (flux_d > flux_thr_i) && (cnt_d > count_thr_i);
      flux_out_q <= flux_d;
      cnt_out_q  <= cnt_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.detected     = det_q;
  assign res_o.flux_sum     = flux_out_q;
  assign res_o.active_count = cnt_out_q;

endmodule

// ----- rtl/spectral_flux_shot_detector.sv -----
// Top level of the spectral flux shot detector: config registers, bin counter,
// previous-frame cell chain and accumulator. Depends on sfsd_pkg, sfsd_if,
// sfsd_cell and sfsd_accum.
//
//   channel   dir  beat                                      handshake
//   mag_i     in   one spectrum bin (magnitude, signed 16b)  valid/ready
//   res_o     out  one frame result (detected, flux, count)  valid/ready
//   cfg       in   register write (cfg_idx_i, cfg_data_i)    cfg_we_i, no wait
//
// One bin beat per cycle while the last bin is not stalled; the result of a frame
// is registered by the clock edge that takes its last bin.
// Only the last bin of a frame can stall: it waits while the previous result
// still sits untaken in the output register. Other bins are always taken.
// Reset: bin counter and sums to zero, every cell of the previous frame to
// zero, registers to their reset values. No clearing pass.
module spectral_flux_shot_detector import sfsd_pkg::*; #(
  parameter int unsigned BINS = SFSD_BINS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sfsd_mag_if.sink             mag_i,
  sfsd_res_if.source           res_o
);

  localparam int unsigned POS_W = $clog2(BINS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BINS - 1);

  logic [FLUX_W-1:0]     flux_thr_q;
  logic [CNT_W-1:0]      count_thr_q;
  logic [CFG_W-1:0]      floor_low_q;
  logic [CFG_W-1:0]      floor_high_q;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic                  is_last;
  logic                  accept;
  step_t                 step;
  logic [2*CFG_W-1:0]    floors;
  logic [6:0]            floor_idx;
  logic [FLOOR_W-1:0]    floor_nib;
  logic signed [MAG_W-1:0] tap [BINS+1];

  // ---- configuration registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flux_thr_q   <= FLUX_THR_RST;
      count_thr_q  <= COUNT_THR_RST;
      floor_low_q  <= FLOOR_LOW_RST;
      floor_high_q <= FLOOR_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FLUX_THR:   flux_thr_q   <= cfg_data_i[FLUX_W-1:0];
        REG_COUNT_THR:  count_thr_q  <= cfg_data_i[CNT_W-1:0];
        REG_FLOOR_LOW:  floor_low_q  <= cfg_data_i;
        REG_FLOOR_HIGH: floor_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- bin sequencer ----
  assign is_last     = (pos_q == LAST_POS);
  // hold the last bin back only while the output register is still full
  assign mag_i.ready = !(is_last && res_o.valid);
  assign accept      = mag_i.valid && mag_i.ready;

  assign step.accept = accept;
  assign step.first  = (pos_q == '0);
  assign step.last   = is_last;

  assign pos_d = is_last ? '0 : pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  // noise floor nibble of the current bin
  assign floors    = {floor_high_q, floor_low_q};
  assign floor_idx = {5'(pos_q), 2'b00};
  assign floor_nib = floors[floor_idx +: FLOOR_W];

  // ---- previous-frame chain ----
  // Bins arrive in order, so the cell at the far end always holds the same
  // bin of the frame before: each beat shifts the whole row by one cell.
  assign tap[0] = mag_i.magnitude;

  for (genvar k = 0; k < BINS; k++) begin : g_cell
    sfsd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(accept),
      .mag_i  (tap[k]),
      .mag_o  (tap[k+1])
    );
  end

  // ---- accumulation and result register ----
  sfsd_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .mag_i      (mag_i.magnitude),
    .prev_i     (tap[BINS]),
    .floor_i    (floor_nib),
    .flux_thr_i (flux_thr_q),
    .count_thr_i(count_thr_q),
    .res_o      (res_o)
  );

endmodule
